// ----- rtl/range_min_segment_tree_top_assert.svh -----
// Assertion macros for the range minimum segment tree.
// Both expect clk and arst_n in scope.
`ifndef RANGE_MIN_SEGMENT_TREE_TOP_ASSERT_SVH
`define RANGE_MIN_SEGMENT_TREE_TOP_ASSERT_SVH

// Same-cycle implication
`define RMST_AST_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmst: same-cycle check failed");

// Next-cycle implication
`define RMST_AST_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmst: next-cycle check failed");

`endif

// ----- rtl/rmst_pkg.sv -----
// ----------------------------------------------------------------------------
// rmst_pkg
// Field widths, action codes and node reset value of the range minimum tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

	localparam int POS_W = 10;
	localparam int VAL_W = 32;
	localparam int QRY_W = 11;

	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	// Identity of min: every node holds this after reset
	localparam logic signed [VAL_W-1:0] NODE_RESET = 32'sh7FFF_FFFF;

endpackage

// ----- rtl/rmst_if.sv -----
// ----------------------------------------------------------------------------
// rmst_req_if / rmst_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface rmst_req_if import rmst_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    action;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] new_value;
	logic [QRY_W-1:0]        query_start;
	logic [QRY_W-1:0]        query_end;

	modport source (output valid, action, position, new_value, query_start, query_end,
		input ready);
	modport sink (input valid, action, position, new_value, query_start, query_end,
		output ready);
endinterface

interface rmst_rsp_if import rmst_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] min_value;
	logic                    empty_range;

	modport source (output valid, min_value, empty_range, input ready);
	modport sink (input valid, min_value, empty_range, output ready);
endinterface

// ----- rtl/rmst_ram.sv -----
// ----------------------------------------------------------------------------
// rmst_ram
// Node store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rmst_ram import rmst_pkg::*; #(
	parameter int AW = 11
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic signed [VAL_W-1:0] wdata,
	input  logic [AW-1:0]           raddr_a,
	input  logic [AW-1:0]           raddr_b,
	output logic signed [VAL_W-1:0] rdata_a,
	output logic signed [VAL_W-1:0] rdata_b
);

	logic signed [VAL_W-1:0] mem [2**AW];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- rtl/range_min_segment_tree_top.sv -----
// ----------------------------------------------------------------------------
// range_min_segment_tree_top
// Range minimum segment tree over LEAVES signed words, held in one node RAM.
//
//   channel  dir  word                                                  
//   req      in   action, position, new_value, query_start, query_end  
//   rsp      out  min_value, empty_range (one word per query)          
//
// Nodes sit in heap order from address 1; leaf p lives at LEAVES + p.
// After reset a clearing pass writes every RAM entry, one per cycle, and
// req.ready stays low until the pass ends.
// An update makes one RAM write per tree level, the sibling read overlapping
// the write of the level below.
// In a query the bottom-up walk reads two nodes per level over the RAM's two
// read ports, then the read pipe drains.
// A waiting result word does not stall updates; a finished query holds until
// the result register is free.
// ----------------------------------------------------------------------------
module range_min_segment_tree_top import rmst_pkg::*; #(
	parameter int LEAVES = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	rmst_req_if.sink  req,
	rmst_rsp_if.source rsp
);

	localparam int AW = $clog2(LEAVES) + 1;
	localparam int NW = AW + 1;
	localparam int CW = (NW > QRY_W) ? NW : QRY_W;
	localparam logic [CW-1:0] LEAVES_C = CW'(LEAVES);
	localparam logic [NW-1:0] LEAVES_N = NW'(LEAVES);
	localparam logic [AW-1:0] LEAVES_A = AW'(LEAVES);
	localparam logic [AW-1:0] ROOT     = AW'(1);
	localparam logic [AW-1:0] CLR_LAST = '1;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_UPD   = 5'b00100,
		S_QRY   = 5'b01000,
		S_QFIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [AW-1:0]           clr_q;
	logic [AW-1:0]           node_q;
	logic signed [VAL_W-1:0] val_q;
	logic [NW-1:0]           l_q, r_q;
	logic signed [VAL_W-1:0] acc_q;
	logic                    empty_q;
	logic                    valid_s1, use_a_s1, use_b_s1;
	logic                    valid_s2;
	logic signed [VAL_W-1:0] pair_s2;
	logic                    rsp_valid_q, rsp_empty_q;
	logic signed [VAL_W-1:0] rsp_min_q;

	logic                    we;
	logic [AW-1:0]           waddr, raddr_a, raddr_b;
	logic signed [VAL_W-1:0] wdata, rdata_a, rdata_b;

	logic                    accept, pos_ok, q_empty, q_issue, q_done, out_free;
	logic [CW-1:0]           pos_c, qs_c, qe_c, qb_c;
	logic [AW-1:0]           leaf_addr, parent;
	logic [NW-1:0]           r_last, l_next, r_next;
	logic signed [VAL_W-1:0] upd_min, op_a, op_b, pair_min;

	rmst_ram #(.AW(AW)) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Decode the request word
	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign pos_c     = CW'(req.position);
	assign qs_c      = CW'(req.query_start);
	assign qe_c      = CW'(req.query_end);
	assign qb_c      = (qe_c > LEAVES_C) ? LEAVES_C : qe_c;
	assign q_empty   = (qs_c >= qb_c);
	assign pos_ok    = (pos_c < LEAVES_C);
	assign leaf_addr = LEAVES_A + AW'(pos_c);

	// Update climb: parent gets min of the carried value and the sibling
	assign parent  = node_q >> 1;
	assign upd_min = (rdata_a < val_q) ? rdata_a : val_q;

	// Query walk: take odd left bound and odd right bound, then go up a level
	assign q_issue = (state_q == S_QRY) && (l_q < r_q);
	assign r_last  = r_q - NW'(1);
	assign l_next  = (l_q + NW'(l_q[0])) >> 1;
	assign r_next  = (r_q - NW'(r_q[0])) >> 1;

	// Mask unused reads to the min identity
	assign op_a     = use_a_s1 ? rdata_a : NODE_RESET;
	assign op_b     = use_b_s1 ? rdata_b : NODE_RESET;
	assign pair_min = (op_b < op_a) ? op_b : op_a;

	assign q_done   = !valid_s1 && !valid_s2;
	assign out_free = !rsp_valid_q || rsp.ready;

	// Steer the RAM ports
	always_comb begin
		we      = 1'b0;
		waddr   = leaf_addr;
		wdata   = req.new_value;
		raddr_a = {leaf_addr[AW-1:1], ~leaf_addr[0]};
		raddr_b = r_last[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = NODE_RESET;
			end
			S_IDLE: begin
				we = accept && (req.action == ACT_UPDATE) && pos_ok;
			end
			S_UPD: begin
				we      = 1'b1;
				waddr   = parent;
				wdata   = upd_min;
				raddr_a = {parent[AW-1:1], ~parent[0]};
			end
			S_QRY: begin
				raddr_a = l_q[AW-1:0];
			end
			default: ;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == CLR_LAST) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					unique case (req.action)
						ACT_UPDATE: if (pos_ok) state_d = S_UPD;
						ACT_QUERY:  state_d = q_empty ? S_QFIN : S_QRY;
						default:    ;
					endcase
				end
			end
			S_UPD:  if (parent == ROOT) state_d = S_IDLE;
			S_QRY:  if (!q_issue) state_d = S_QFIN;
			S_QFIN: if (q_done && out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= q_issue;
			valid_s2 <= valid_s1;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == S_QFIN && q_done && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// Load the item on accept
		if (accept) begin
			node_q  <= leaf_addr;
			val_q   <= req.new_value;
			l_q     <= LEAVES_N + NW'(qs_c);
			r_q     <= LEAVES_N + NW'(qb_c);
			acc_q   <= NODE_RESET;
			empty_q <= q_empty;
		end
		// Advance the update climb
		if (state_q == S_UPD) begin
			node_q <= parent;
			val_q  <= upd_min;
		end
		// Advance the query bounds
		if (q_issue) begin
			l_q <= l_next;
			r_q <= r_next;
		end
		use_a_s1 <= l_q[0];
		use_b_s1 <= r_q[0];
		pair_s2  <= pair_min;
		// Fold each level pair into the running minimum
		if (valid_s2) begin
			acc_q <= (pair_s2 < acc_q) ? pair_s2 : acc_q;
		end
		// Load the result word
		if (state_q == S_QFIN && q_done && out_free) begin
			rsp_min_q   <= empty_q ? '0 : acc_q;
			rsp_empty_q <= empty_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.min_value   = rsp_min_q;
	assign rsp.empty_range = rsp_empty_q;

	`include "range_min_segment_tree_top_assert.svh"

	`RMST_AST_IMP(a_clear_blocks_req, state_q == S_CLEAR, !req.ready)
	`RMST_AST_IMP(a_empty_min_zero, rsp.valid && rsp.empty_range, rsp.min_value == '0)
	`RMST_AST_IMP(a_pipe_only_query, valid_s1 || valid_s2, state_q == S_QRY || state_q == S_QFIN)
	`RMST_AST_NXT(a_upd_reaches_idle, state_q == S_UPD && parent == ROOT, state_q == S_IDLE)

endmodule
